// ----- rtl/zci_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// zci_pkg
// Shared constants and controller/datapath interface types for the
// zero-crossing interpolator.
// ----------------------------------------------------------------------------
package zci_pkg;

  localparam int unsigned SampleBitsDef = 16;
  localparam int unsigned FracBitsDef   = 16;
  localparam int unsigned IdxBits       = 32;
  localparam int unsigned OutFracBits   = 16;

  // crossing kinds
  localparam logic KIND_INTERP = 1'b0;
  localparam logic KIND_MIDRUN = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic div_step;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sign_hit;
    logic mid_hit;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ----- rtl/zci_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// zci_ctrl
// Sequencer: accepts a sample, runs the divider for a sign crossing, hands the result on.
// ----------------------------------------------------------------------------
module zci_ctrl #(
  parameter int unsigned FRAC_BITS = zci_pkg::FracBitsDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire zci_pkg::sts_t sts_i,
  output zci_pkg::cmd_t      cmd_o
);

  localparam int unsigned CntW = $clog2(FRAC_BITS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    s_axis_tready = 1'b0;
    cmd_o         = '0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.accept = 1'b1;
          if (sts_i.sign_hit) begin
            cnt_d   = CntW'(FRAC_BITS - 1);
            state_d = ST_DIV;
          end else if (sts_i.mid_hit) begin
            state_d = ST_OUT;
          end
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_OUT;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_OUT: begin
        // hold until the output register has room
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/zci_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// zci_dp
// Datapath: sample history, zero-run tracking, restoring divider and
// output register.
// ----------------------------------------------------------------------------
module zci_dp #(
  parameter int unsigned SAMPLE_BITS = zci_pkg::SampleBitsDef,
  parameter int unsigned FRAC_BITS   = zci_pkg::FracBitsDef
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire zci_pkg::cmd_t                      cmd_i,
  output zci_pkg::sts_t                           sts_o,
  input  wire logic signed [SAMPLE_BITS-1:0]      sample_i,
  input  wire logic                               cfg_we_i,
  input  wire logic                               cfg_data_i,
  input  wire logic                               out_ready_i,
  output logic                                    out_valid_o,
  output logic [zci_pkg::IdxBits-1:0]             out_index_o,
  output logic [zci_pkg::OutFracBits-1:0]         out_fraction_o,
  output logic                                    out_kind_o
);

  localparam int unsigned IW = zci_pkg::IdxBits;
  localparam int unsigned OF = zci_pkg::OutFracBits;
  localparam int unsigned RW = SAMPLE_BITS + 2;

  // history and run state
  logic                          negate_q;
  logic signed [SAMPLE_BITS-1:0] prev_q;
  logic                          have_prev_q;
  logic                          in_run_q;
  logic [IW-1:0]                 counter_q;
  logic [IW-1:0]                 run_start_q;
  logic [IW-1:0]                 run_len_q;

  // result under construction
  logic [IW-1:0]        res_idx_q;
  logic [FRAC_BITS-1:0] res_frac_q;
  logic                 res_kind_q;
  logic [RW-1:0]        rem_q;
  logic [SAMPLE_BITS:0] den_q;

  // output register
  logic                 out_valid_q;
  logic [IW-1:0]        out_idx_q;
  logic [OF-1:0]        out_frac_q;
  logic                 out_kind_q;

  logic                   is_zero;
  logic                   dir_hit;
  logic [SAMPLE_BITS-1:0] mag_a, mag_b;
  logic [FRAC_BITS-1:0]   half_frac;
  logic [RW-1:0]          trial;
  logic                   ge;
  logic [FRAC_BITS+OF-1:0] frac_wide;

  assign is_zero   = (sample_i == '0);
  assign dir_hit   = negate_q ? (prev_q > 0 && sample_i < 0) : (prev_q < 0 && sample_i > 0);
  assign mag_a     = prev_q[SAMPLE_BITS-1] ? SAMPLE_BITS'(-prev_q) : SAMPLE_BITS'(prev_q);
  assign mag_b     = sample_i[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample_i) : SAMPLE_BITS'(sample_i);
  assign half_frac = FRAC_BITS'(1) << (FRAC_BITS - 1);

  assign sts_o.mid_hit  = in_run_q && !is_zero;
  assign sts_o.sign_hit = !in_run_q && !is_zero && have_prev_q && (prev_q != '0) && dir_hit;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // one restoring step: shift, trial subtract
  assign trial = {rem_q[RW-2:0], 1'b0};
  assign ge    = (trial >= RW'(den_q));

  // mask or widen the fraction to the output field
  assign frac_wide = {{OF{1'b0}}, res_frac_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      negate_q    <= 1'b0;
      prev_q      <= '0;
      have_prev_q <= 1'b0;
      in_run_q    <= 1'b0;
      counter_q   <= '0;
      run_start_q <= '0;
      run_len_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        negate_q <= cfg_data_i;
      end
      if (cmd_i.accept) begin
        prev_q      <= sample_i;
        have_prev_q <= 1'b1;
        counter_q   <= counter_q + 1'b1;
        if (in_run_q) begin
          if (is_zero) begin
            // saturate a very long run
            if (run_len_q != '1) begin
              run_len_q <= run_len_q + 1'b1;
            end
          end else begin
            in_run_q <= 1'b0;
          end
        end else if (is_zero) begin
          in_run_q    <= 1'b1;
          run_start_q <= counter_q;
          run_len_q   <= IW'(1);
        end
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      if (in_run_q) begin
        res_idx_q  <= run_start_q + (run_len_q >> 1);
        res_frac_q <= run_len_q[0] ? half_frac : '0;
        res_kind_q <= zci_pkg::KIND_MIDRUN;
      end else begin
        res_idx_q  <= counter_q - 1'b1;
        res_frac_q <= '0;
        res_kind_q <= zci_pkg::KIND_INTERP;
      end
      rem_q <= RW'(mag_a);
      den_q <= (SAMPLE_BITS + 1)'(mag_a) + (SAMPLE_BITS + 1)'(mag_b);
    end else if (cmd_i.div_step) begin
      rem_q      <= ge ? (trial - RW'(den_q)) : trial;
      res_frac_q <= {res_frac_q[FRAC_BITS-2:0], ge};
    end
    if (cmd_i.load_out) begin
      out_idx_q  <= res_idx_q;
      out_frac_q <= frac_wide[OF-1:0];
      out_kind_q <= res_kind_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_index_o    = out_idx_q;
  assign out_fraction_o = out_frac_q;
  assign out_kind_o     = out_kind_q;

endmodule
`default_nettype wire

// ----- rtl/zero_crossing_interpolator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// zero_crossing_interpolator
// Sign-change detector with linearly interpolated crossing time.
// ----------------------------------------------------------------------------
// Samples are numbered from 0 with a wrapping 32-bit counter. A crossing in
// the selected direction (negative to positive, or positive to negative when
// negate_polarity is set) between two nonzero samples is reported at the
// index of the earlier sample plus |a|/(|a|+|b|) with FRAC_BITS fraction
// bits, truncated; a run of zero samples gives one crossing at its midpoint
// when the run ends, whatever the direction. A sample that gives no result
// leaves the sequencer idle, ready for the next. A zero-run midpoint passes
// through ST_OUT before the next sample is taken; an interpolated crossing
// passes through ST_DIV, where the restoring divider forms one quotient bit
// per cycle, then ST_OUT. Once a result has moved into the output register
// the next sample is taken, even while that result waits on m_axis_tready.
// ----------------------------------------------------------------------------
module zero_crossing_interpolator #(
  parameter int unsigned SAMPLE_BITS = zci_pkg::SampleBitsDef,
  parameter int unsigned FRAC_BITS   = zci_pkg::FracBitsDef,
  localparam int unsigned InW        = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  // sample stream
  input  wire logic           s_axis_tvalid,
  output logic                s_axis_tready,
  input  wire logic [InW-1:0] s_axis_tdata,   // [SAMPLE_BITS-1:0] sample_value
  // crossing stream
  output logic                m_axis_tvalid,
  input  wire logic           m_axis_tready,
  output logic [47:0]         m_axis_tdata,   // [31:0] crossing_index,
                                              // [47:32] crossing_fraction
  output logic                m_axis_tuser,   // [0] crossing_kind
  // negate_polarity register write
  input  wire logic           cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire logic           cfg_data_i
);

  zci_pkg::cmd_t cmd;
  zci_pkg::sts_t sts;

  logic [zci_pkg::IdxBits-1:0]     out_index;
  logic [zci_pkg::OutFracBits-1:0] out_fraction;

  // register writes complete at once
  assign cfg_ready_o = 1'b1;

  zci_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  zci_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .sample_i       (s_axis_tdata[SAMPLE_BITS-1:0]),
    .cfg_we_i       (cfg_valid_i & cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .out_index_o    (out_index),
    .out_fraction_o (out_fraction),
    .out_kind_o     (m_axis_tuser)
  );

  // index in the low bits, fraction above it
  assign m_axis_tdata = {out_fraction, out_index};

endmodule
`default_nettype wire
